// ===== hdl/osh_pkg.sv =====
`timescale 1ns / 1ps

package osh_pkg;

    localparam int MAX_LEN     = 4096;
    localparam int TABLE_DEPTH = 4096;

    localparam int POS_W  = $clog2(MAX_LEN + 1);
    localparam int BUF_AW = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TBL_AW = $clog2(TABLE_DEPTH);

    localparam int HASH_W = 30;
    localparam int KEY_W  = 61;
    localparam int CHAR_W = 8;
    localparam int MUL_CW = $clog2(CHAR_W);

    localparam logic [HASH_W-1:0] MOD_A  = 30'd1000000009;
    localparam logic [HASH_W-1:0] MOD_B  = 30'd1000000007;
    localparam logic [CHAR_W-1:0] BASE_A = 8'd37;
    localparam logic [CHAR_W-1:0] BASE_B = 8'd31;

    localparam logic [CHAR_W-1:0] ALT_FIRST_RST = 8'd97;
    localparam logic [CHAR_W-1:0] ALT_LAST_RST  = 8'd99;

    localparam logic CFG_ALT_FIRST = 1'b0;
    localparam logic CFG_ALT_LAST  = 1'b1;

    typedef enum logic [2:0] {
        STS_INSERTED = 3'd0,
        STS_PRESENT  = 3'd1,
        STS_FULL     = 3'd2,
        STS_MATCH    = 3'd3,
        STS_NO_MATCH = 3'd4,
        STS_TOO_LONG = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        MS_CHAR,
        MS_BASE,
        MS_QC,
        MS_QJ,
        MS_QPOW
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHAR,
        ST_MUL_C,
        ST_MUL_P,
        ST_CHK_LAST,
        ST_SC_RD,
        ST_SC_CMP,
        ST_Q_POS,
        ST_Q_RDC,
        ST_Q_MULC,
        ST_Q_MULJ,
        ST_Q_TRY,
        ST_Q_STEP,
        ST_Q_MULP,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic     acc_item;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     hash_add;
        logic     pow_load;
        logic     key_hash;
        logic     key_cand;
        logic     scan_clr;
        logic     scan_inc;
        logic     q_init;
        logic     ba_load;
        logic     cand_load;
        logic     cand_step;
        logic     qpow_load;
        logic     key_write;
        logic     status_set;
        t_status  status;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic too_long;
        logic mode;
        logic last;
        logic pos_full;
        logic scan_end;
        logic scan_hit;
        logic table_full;
        logic q_end;
        logic j_over;
        logic j_eq_c;
        logic out_free;
    } t_stat;

    function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b,
                                                 input logic [HASH_W-1:0] m);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[HASH_W-1:0];
    endfunction

    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                 input logic [HASH_W-1:0] b,
                                                 input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0] d;
        if (a >= b) begin
            d = a - b;
        end else begin
            d = a + (m - b);
        end
        return d;
    endfunction

    // One step of a most-significant-bit-first modular multiply.
    function automatic logic [HASH_W-1:0] mm_step(input logic [HASH_W-1:0] acc,
                                                 input logic [HASH_W-1:0] x,
                                                 input logic              b,
                                                 input logic [HASH_W-1:0] m);
        logic [HASH_W-1:0] dbl;
        dbl = add_mod(acc, acc, m);
        return add_mod(dbl, b ? x : '0, m);
    endfunction

endpackage

// ===== hdl/osh_mulmod.sv =====
`timescale 1ns / 1ps

module osh_mulmod import osh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_x_a,
    input  logic [CHAR_W-1:0] i_y_a,
    input  logic [HASH_W-1:0] i_x_b,
    input  logic [CHAR_W-1:0] i_y_b,
    output logic              o_done,
    output logic [HASH_W-1:0] o_res_a,
    output logic [HASH_W-1:0] o_res_b
);

    logic                       r_busy;
    logic                       r_done;
    logic [MUL_CW-1:0]          r_cnt;
    logic [HASH_W-1:0]          r_acc_a, r_acc_b, r_x_a, r_x_b;
    logic [CHAR_W-1:0]          r_y_a, r_y_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == MUL_CW'(CHAR_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CW'(CHAR_W - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
            r_x_a   <= i_x_a;
            r_x_b   <= i_x_b;
            r_y_a   <= i_y_a;
            r_y_b   <= i_y_b;
        end else if (r_busy) begin
            r_acc_a <= mm_step(r_acc_a, r_x_a, r_y_a[CHAR_W-1], MOD_A);
            r_acc_b <= mm_step(r_acc_b, r_x_b, r_y_b[CHAR_W-1], MOD_B);
            r_y_a   <= {r_y_a[CHAR_W-2:0], 1'b0};
            r_y_b   <= {r_y_b[CHAR_W-2:0], 1'b0};
        end
    end

    assign o_done  = r_done;
    assign o_res_a = r_acc_a;
    assign o_res_b = r_acc_b;

endmodule

// ===== hdl/osh_datapath.sv =====
`timescale 1ns / 1ps

module osh_datapath import osh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_mode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_index,
    input  logic [CHAR_W-1:0] i_cfg_data,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [2:0]        o_status
);

    logic [CHAR_W-1:0] r_alt_first, r_alt_last;
    logic [HASH_W-1:0] r_hash_a, r_hash_b, r_pow_a, r_pow_b;
    logic [POS_W-1:0]  r_pos, r_qi;
    logic              r_too_long;
    logic [CNT_W-1:0]  r_key_count, r_scan;
    logic              r_mode, r_last;
    logic [CHAR_W-1:0] r_cur_c;
    logic [HASH_W-1:0] r_qpow_a, r_qpow_b, r_ba_a, r_ba_b, r_cand_a, r_cand_b;
    logic [CHAR_W:0]   r_j;
    logic [KEY_W-1:0]  r_key;
    t_status           r_pend;
    logic              r_out_valid;
    logic [2:0]        r_status;

    logic [CHAR_W-1:0] buf_mem [MAX_LEN];
    logic [CHAR_W-1:0] r_buf_rd;
    logic [KEY_W-1:0]  key_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_tbl_rd;

    logic              pos_full;
    logic [HASH_W-1:0] mx_a, mx_b, mres_a, mres_b;
    logic [CHAR_W-1:0] my_a, my_b;
    logic              mdone;

    assign pos_full = (r_pos >= POS_W'(MAX_LEN));

    always_comb begin
        mx_a = r_pow_a;
        mx_b = r_pow_b;
        my_a = r_cur_c;
        my_b = r_cur_c;
        case (i_cmd.mul_sel)
            MS_CHAR: begin
                mx_a = r_pow_a;
                mx_b = r_pow_b;
                my_a = r_cur_c;
                my_b = r_cur_c;
            end
            MS_BASE: begin
                mx_a = r_pow_a;
                mx_b = r_pow_b;
                my_a = BASE_A;
                my_b = BASE_B;
            end
            MS_QC: begin
                mx_a = r_qpow_a;
                mx_b = r_qpow_b;
                my_a = r_buf_rd;
                my_b = r_buf_rd;
            end
            MS_QJ: begin
                mx_a = r_qpow_a;
                mx_b = r_qpow_b;
                my_a = r_alt_first;
                my_b = r_alt_first;
            end
            MS_QPOW: begin
                mx_a = r_qpow_a;
                mx_b = r_qpow_b;
                my_a = BASE_A;
                my_b = BASE_B;
            end
            default: begin
                mx_a = r_pow_a;
                mx_b = r_pow_b;
                my_a = r_cur_c;
                my_b = r_cur_c;
            end
        endcase
    end

    osh_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_x_a   (mx_a),
        .i_y_a   (my_a),
        .i_x_b   (mx_b),
        .i_y_b   (my_b),
        .o_done  (mdone),
        .o_res_a (mres_a),
        .o_res_b (mres_b)
    );

    // String state, key count, configuration and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt_first <= ALT_FIRST_RST;
            r_alt_last  <= ALT_LAST_RST;
            r_hash_a    <= '0;
            r_hash_b    <= '0;
            r_pow_a     <= HASH_W'(1);
            r_pow_b     <= HASH_W'(1);
            r_pos       <= '0;
            r_too_long  <= 1'b0;
            r_key_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_ALT_FIRST) begin
                    r_alt_first <= i_cfg_data;
                end else begin
                    r_alt_last <= i_cfg_data;
                end
            end
            if (i_cmd.acc_item && pos_full) begin
                r_too_long <= 1'b1;
            end
            if (i_cmd.hash_add) begin
                r_hash_a <= add_mod(r_hash_a, mres_a, MOD_A);
                r_hash_b <= add_mod(r_hash_b, mres_b, MOD_B);
            end
            if (i_cmd.pow_load) begin
                r_pow_a <= mres_a;
                r_pow_b <= mres_b;
                r_pos   <= r_pos + 1'b1;
            end
            if (i_cmd.key_write) begin
                r_key_count <= r_key_count + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_hash_a    <= '0;
                r_hash_b    <= '0;
                r_pow_a     <= HASH_W'(1);
                r_pow_b     <= HASH_W'(1);
                r_pos       <= '0;
                r_too_long  <= 1'b0;
            end
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_item) begin
            r_mode  <= i_mode;
            r_last  <= i_last_char;
            r_cur_c <= i_char_code;
        end
        if (i_cmd.mul_start && i_cmd.mul_sel == MS_QC) begin
            r_cur_c <= r_buf_rd;
        end
        if (i_cmd.q_init) begin
            r_qi     <= '0;
            r_qpow_a <= HASH_W'(1);
            r_qpow_b <= HASH_W'(1);
        end
        if (i_cmd.ba_load) begin
            r_ba_a <= sub_mod(r_hash_a, mres_a, MOD_A);
            r_ba_b <= sub_mod(r_hash_b, mres_b, MOD_B);
            r_j    <= {1'b0, r_alt_first};
        end
        if (i_cmd.cand_load) begin
            r_cand_a <= add_mod(r_ba_a, mres_a, MOD_A);
            r_cand_b <= add_mod(r_ba_b, mres_b, MOD_B);
        end
        if (i_cmd.cand_step) begin
            r_cand_a <= add_mod(r_cand_a, r_qpow_a, MOD_A);
            r_cand_b <= add_mod(r_cand_b, r_qpow_b, MOD_B);
            r_j      <= r_j + 1'b1;
        end
        if (i_cmd.qpow_load) begin
            r_qpow_a <= mres_a;
            r_qpow_b <= mres_b;
            r_qi     <= r_qi + 1'b1;
        end
        if (i_cmd.key_hash) begin
            r_key <= {r_hash_a, 1'b0, r_hash_b};
        end
        if (i_cmd.key_cand) begin
            r_key <= {r_cand_a, 1'b0, r_cand_b};
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.status_set) begin
            r_pend <= i_cmd.status;
        end
        if (i_cmd.out_load) begin
            r_status <= r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_item && !pos_full) begin
            buf_mem[r_pos[BUF_AW-1:0]] <= i_char_code;
        end
        r_buf_rd <= buf_mem[r_qi[BUF_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_write) begin
            key_mem[r_key_count[TBL_AW-1:0]] <= r_key;
        end
        r_tbl_rd <= key_mem[r_scan[TBL_AW-1:0]];
    end

    always_comb begin
        o_stat.mul_done   = mdone;
        o_stat.too_long   = r_too_long;
        o_stat.mode       = r_mode;
        o_stat.last       = r_last;
        o_stat.pos_full   = pos_full;
        o_stat.scan_end   = (r_scan == r_key_count);
        o_stat.scan_hit   = (r_tbl_rd == r_key);
        o_stat.table_full = (r_key_count >= CNT_W'(TABLE_DEPTH));
        o_stat.q_end      = (r_qi == r_pos);
        o_stat.j_over     = (r_j > {1'b0, r_alt_last});
        o_stat.j_eq_c     = (r_j == {1'b0, r_cur_c});
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

// ===== hdl/osh_ctrl.sv =====
`timescale 1ns / 1ps

module osh_ctrl import osh_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.mul_sel = MS_CHAR;
        o_cmd.status  = STS_INSERTED;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc_item = 1'b1;
                    n_state = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (i_stat.pos_full) begin
                    n_state = ST_CHK_LAST;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_CHAR;
                    n_state = ST_MUL_C;
                end
            end
            ST_MUL_C: begin
                if (i_stat.mul_done) begin
                    o_cmd.hash_add  = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_BASE;
                    n_state = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                if (i_stat.mul_done) begin
                    o_cmd.pow_load = 1'b1;
                    n_state = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST: begin
                if (!i_stat.last) begin
                    n_state = ST_IDLE;
                end else if (i_stat.too_long) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STS_TOO_LONG;
                    n_state = ST_REPORT;
                end else if (!i_stat.mode) begin
                    o_cmd.key_hash = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = ST_SC_RD;
                end else begin
                    o_cmd.q_init = 1'b1;
                    n_state = ST_Q_POS;
                end
            end
            ST_SC_RD: begin
                if (!i_stat.scan_end) begin
                    n_state = ST_SC_CMP;
                end else if (i_stat.mode) begin
                    n_state = ST_Q_STEP;
                end else if (i_stat.table_full) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STS_FULL;
                    n_state = ST_REPORT;
                end else begin
                    o_cmd.key_write  = 1'b1;
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STS_INSERTED;
                    n_state = ST_REPORT;
                end
            end
            ST_SC_CMP: begin
                if (i_stat.scan_hit) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = i_stat.mode ? STS_MATCH : STS_PRESENT;
                    n_state = ST_REPORT;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                    n_state = ST_SC_RD;
                end
            end
            ST_Q_POS: begin
                if (i_stat.q_end) begin
                    o_cmd.status_set = 1'b1;
                    o_cmd.status     = STS_NO_MATCH;
                    n_state = ST_REPORT;
                end else begin
                    n_state = ST_Q_RDC;
                end
            end
            ST_Q_RDC: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_QC;
                n_state = ST_Q_MULC;
            end
            ST_Q_MULC: begin
                if (i_stat.mul_done) begin
                    o_cmd.ba_load   = 1'b1;
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_QJ;
                    n_state = ST_Q_MULJ;
                end
            end
            ST_Q_MULJ: begin
                if (i_stat.mul_done) begin
                    o_cmd.cand_load = 1'b1;
                    n_state = ST_Q_TRY;
                end
            end
            ST_Q_TRY: begin
                if (i_stat.j_over) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MS_QPOW;
                    n_state = ST_Q_MULP;
                end else if (i_stat.j_eq_c) begin
                    n_state = ST_Q_STEP;
                end else begin
                    o_cmd.key_cand = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = ST_SC_RD;
                end
            end
            ST_Q_STEP: begin
                o_cmd.cand_step = 1'b1;
                n_state = ST_Q_TRY;
            end
            ST_Q_MULP: begin
                if (i_stat.mul_done) begin
                    o_cmd.qpow_load = 1'b1;
                    n_state = ST_Q_POS;
                end
            end
            ST_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/one_substitution_hash_dictionary.sv =====
`timescale 1ns / 1ps
// Channel  | Handshake                  | Payload
// input    | i_in_valid / o_in_ready    | i_mode, i_char_code, i_last_char
// result   | o_out_valid / i_out_ready  | o_status
// config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Each character within the buffer length takes two 8-step serial modular multiplies
// (weight times character, weight times base) in the shared multiply unit.
// A dictionary end scans the stored keys in the table; a query end multiplies at
// each position and scans the table for each substitute of that position's character.
// Reset is synchronous and active low; the key table needs no clearing pass.
// A finished result waits in the output register; the next item is taken meanwhile.

module one_substitution_hash_dictionary import osh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_mode,
    input  logic [CHAR_W-1:0] i_char_code,
    input  logic              i_last_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CHAR_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    osh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    osh_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_mode),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_status    (o_status)
    );

endmodule

// ===== hdl/osh_checker.sv =====
`timescale 1ns / 1ps

module osh_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_last_char,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped or changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= 3'd5)
        else $error("status code out of range");

    a_no_result_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_last_char |=> !$rose(o_out_valid))
        else $error("result raised by a non-final character");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again before the character was hashed");

endmodule

bind one_substitution_hash_dictionary osh_checker u_osh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_last_char (i_last_char),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import osh_pkg::*;

    localparam longint P_A = 1000000009;
    localparam longint P_B = 1000000007;
    localparam longint W_A = 37;
    localparam longint W_B = 31;
    localparam int     CYCLE_LIMIT = 4000000;
    localparam int     RAND_ITEMS  = 1450;

    typedef struct {
        bit       mode;
        bit [7:0] ch;
        bit       last;
    } t_char_item;

    typedef struct {
        int       n;
        bit [7:0] c [0:5];
    } t_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              i_mode = 1'b0;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic              i_last_char = 1'b0;
    logic              i_out_ready = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              i_cfg_index = CFG_ALT_FIRST;
    logic [CHAR_W-1:0] i_cfg_data = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_cfg_ready;
    logic [2:0]        o_status;

    one_substitution_hash_dictionary dut (.*);

    always #6 i_clk = ~i_clk;

    // Model of the block's state.
    bit [7:0]    sub_lo = ALT_FIRST_RST;
    bit [7:0]    sub_hi = ALT_LAST_RST;
    longint      acc_a = 0, acc_b = 0, wt_a = 1, wt_b = 1;
    int          str_len = 0;
    bit          overflow = 0;
    bit [7:0]    str_chars [0:MAX_LEN-1];
    logic [60:0] key_table [$];

    t_char_item  pending_chars [$];
    t_status     expected_status [$];
    t_word       dict_words [$];
    int          errors = 0;
    int          cycles = 0;
    int          status_seen = 0;
    bit          calm = 0;

    function automatic longint mul_mod(longint x, longint y, longint m);
        return (x * y) % m;
    endfunction

    function automatic bit key_known(logic [60:0] k);
        foreach (key_table[i]) if (key_table[i] == k) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit one_sub_hit();
        longint pa, pb, ba, bb, na, nb;
        int     c;
        pa = 1;
        pb = 1;
        for (int i = 0; i < str_len; i++) begin
            c  = str_chars[i];
            ba = (acc_a + P_A - mul_mod(pa, c, P_A)) % P_A;
            bb = (acc_b + P_B - mul_mod(pb, c, P_B)) % P_B;
            for (int j = sub_lo; j <= sub_hi; j++) begin
                if (j != c) begin
                    na = (ba + mul_mod(pa, j, P_A)) % P_A;
                    nb = (bb + mul_mod(pb, j, P_B)) % P_B;
                    if (key_known({na[29:0], nb[30:0]})) return 1'b1;
                end
            end
            pa = mul_mod(pa, W_A, P_A);
            pb = mul_mod(pb, W_B, P_B);
        end
        return 1'b0;
    endfunction

    function automatic void absorb_char(t_char_item it);
        logic [60:0] k;
        t_status     st;
        if (str_len < MAX_LEN) begin
            str_chars[str_len] = it.ch;
            acc_a = (acc_a + mul_mod(wt_a, it.ch, P_A)) % P_A;
            acc_b = (acc_b + mul_mod(wt_b, it.ch, P_B)) % P_B;
            wt_a  = mul_mod(wt_a, W_A, P_A);
            wt_b  = mul_mod(wt_b, W_B, P_B);
            str_len++;
        end else begin
            overflow = 1'b1;
        end
        if (!it.last) return;
        k = {acc_a[29:0], acc_b[30:0]};
        if (overflow) begin
            st = STS_TOO_LONG;
        end else if (it.mode == 1'b0) begin
            if (key_known(k)) begin
                st = STS_PRESENT;
            end else if (key_table.size() >= TABLE_DEPTH) begin
                st = STS_FULL;
            end else begin
                key_table.push_back(k);
                st = STS_INSERTED;
            end
        end else begin
            st = one_sub_hit() ? STS_MATCH : STS_NO_MATCH;
        end
        expected_status.push_back(st);
        acc_a = 0;
        acc_b = 0;
        wt_a = 1;
        wt_b = 1;
        str_len = 0;
        overflow = 1'b0;
    endfunction

    // Character sender.
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                absorb_char(pending_chars.pop_front());
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap > 0) begin
                    gap <= gap - 1;
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    gap <= $urandom_range(1, 8) - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_chars.size() > 0) begin
                    i_in_valid  <= 1'b1;
                    i_mode      <= pending_chars[0].mode;
                    i_char_code <= pending_chars[0].ch;
                    i_last_char <= pending_chars[0].last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Status receiver, with one long hold-off so the block backs up.
    int  hold = 0;
    bit  held_once = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                status_seen++;
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected status, expected none, actual %0d",
                             $time, o_status);
                    errors++;
                end else begin
                    if (o_status !== expected_status[0]) begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, expected_status[0], o_status);
                        errors++;
                    end
                    void'(expected_status.pop_front());
                end
            end
            if (!held_once && status_seen == 40) begin
                held_once <= 1'b1;
                hold <= 3000;
                i_out_ready <= 1'b0;
            end else if (hold > 0) begin
                hold <= hold - 1;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                hold <= $urandom_range(1, 8) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic queue_string(input bit m, input bit [7:0] w [$]);
        t_char_item it;
        foreach (w[i]) begin
            it.mode = m;
            it.ch   = w[i];
            it.last = (i == w.size() - 1);
            pending_chars.push_back(it);
        end
    endtask

    task automatic cfg_write(input logic idx, input bit [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ALT_FIRST) sub_lo = d;
        else sub_hi = d;
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_chars.size() > 0 || i_in_valid || expected_status.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic random_strings(input int count);
        bit [7:0] w [$];
        t_word    tw;
        int       sent, r, lo, hi, p;
        sent = 0;
        lo = sub_lo;
        hi = (sub_hi < 255) ? sub_hi + 1 : sub_hi;
        if (lo > hi) lo = hi;
        while (sent < count) begin
            w = {};
            r = $urandom_range(0, 9);
            if (r <= 2 || dict_words.size() == 0) begin
                tw.n = $urandom_range(1, 6);
                for (int i = 0; i < tw.n; i++) begin
                    tw.c[i] = $urandom_range(lo, hi);
                    w.push_back(tw.c[i]);
                end
                dict_words.push_back(tw);
                queue_string(1'b0, w);
            end else if (r <= 8 && r != 7) begin
                tw = dict_words[$urandom_range(0, dict_words.size() - 1)];
                for (int i = 0; i < tw.n; i++) w.push_back(tw.c[i]);
                if (r != 6) begin
                    p = $urandom_range(0, tw.n - 1);
                    w[p] = $urandom_range(lo, hi);
                end
                queue_string(1'b1, w);
            end else begin
                // Noise: arbitrary bytes and per-character modes.
                t_char_item it;
                p = $urandom_range(1, 5);
                for (int i = 0; i < p; i++) begin
                    it.mode = $urandom_range(0, 1);
                    it.ch   = $urandom_range(0, 255);
                    it.last = (i == p - 1);
                    pending_chars.push_back(it);
                end
                tw.n = p;
            end
            sent += (w.size() > 0) ? w.size() : tw.n;
        end
    endtask

    initial begin
        bit [7:0]   w [$];
        t_char_item it;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings under the reset substitute range.
        queue_string(1'b0, '{8'h61, 8'h62, 8'h63});
        queue_string(1'b0, '{8'h61, 8'h62, 8'h63});
        queue_string(1'b0, '{8'h00});
        queue_string(1'b0, '{8'hff});
        queue_string(1'b1, '{8'h62, 8'h62, 8'h63});
        queue_string(1'b1, '{8'h61, 8'h62, 8'h63});
        queue_string(1'b1, '{8'h61, 8'h62, 8'h64});
        // Mixed modes: the final character's mode decides.
        it = '{1'b1, 8'h63, 1'b0}; pending_chars.push_back(it);
        it = '{1'b0, 8'h61, 1'b1}; pending_chars.push_back(it);
        it = '{1'b0, 8'h62, 1'b0}; pending_chars.push_back(it);
        it = '{1'b1, 8'h61, 1'b1}; pending_chars.push_back(it);
        drain();

        cfg_write(CFG_ALT_FIRST, 8'd0);
        cfg_write(CFG_ALT_LAST, 8'd255);
        queue_string(1'b1, '{8'h01});
        queue_string(1'b1, '{8'hff, 8'h00});
        queue_string(1'b1, '{8'h63, 8'h62});
        drain();

        // Empty substitute range.
        cfg_write(CFG_ALT_FIRST, 8'd200);
        cfg_write(CFG_ALT_LAST, 8'd10);
        queue_string(1'b1, '{8'h62, 8'h62, 8'h63});
        drain();

        // A string longer than the buffer.
        w = {};
        for (int i = 0; i < MAX_LEN + 3; i++) w.push_back($urandom_range(0, 255));
        queue_string(1'b0, w);
        queue_string(1'b0, '{8'h7a});
        drain();

        cfg_write(CFG_ALT_FIRST, ALT_FIRST_RST);
        cfg_write(CFG_ALT_LAST, ALT_LAST_RST);
        random_strings(RAND_ITEMS / 3);
        drain();

        cfg_write(CFG_ALT_FIRST, 8'd255);
        cfg_write(CFG_ALT_LAST, 8'd255);
        dict_words = {};
        random_strings(RAND_ITEMS / 6);
        drain();

        cfg_write(CFG_ALT_FIRST, 8'd0);
        cfg_write(CFG_ALT_LAST, 8'd0);
        dict_words = {};
        random_strings(RAND_ITEMS / 6);
        drain();

        cfg_write(CFG_ALT_FIRST, 8'd120);
        cfg_write(CFG_ALT_LAST, 8'd122);
        dict_words = {};
        random_strings(RAND_ITEMS / 6);
        drain();

        calm = 1'b1;
        random_strings(RAND_ITEMS / 6);
        drain();

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
